>>> hdl/qpps_pkg.sv
`default_nettype none

package qpps_pkg;

   // motor count default
   localparam int unsigned MOTOR_COUNT_DEFAULT = 3;

   // port widths
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 72;

   // reset values
   localparam logic [15:0] PWM_PERIOD_RESET   = 16'd4000;
   localparam logic [15:0] GAIN_RESET         = 16'd390;
   localparam logic [2:0]  REVERSE_MASK_RESET = 3'd6;
   localparam logic [15:0] TARGET_LIMIT_RESET = 16'd9999;
   localparam logic [31:0] POSITION_RESET     = 32'd5000;
   localparam logic [15:0] TARGET_RESET       = 16'd5000;

   // quadrature transition table, index {previous phases, new phases}
   localparam logic [15:0] STEP_UP   = 16'h4182;
   localparam logic [15:0] STEP_DOWN = 16'h2814;

   // saturated magnitude of the proportional term
   localparam logic [16:0] MAG_SATURATE = 17'h10000;

   typedef enum logic [1:0] {
      OP_ENCODER    = 2'd0,
      OP_SET_TARGET = 2'd1,
      OP_TICK       = 2'd2,
      OP_READ       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_PWM_PERIOD   = 2'd0,
      CSR_GAIN         = 2'd1,
      CSR_REVERSE_MASK = 2'd2,
      CSR_TARGET_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_MUL,
      ST_EMIT
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic calc;
      logic mul;
      logic emit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic is_tick;
   } dp_status_type;

endpackage

`default_nettype wire

>>> hdl/qpps_ctrl.sv
`default_nettype none

module qpps_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire qpps_pkg::dp_status_type status,
   output qpps_pkg::dp_cmd_type        cmd
);

   qpps_pkg::ctrl_state_type state_ff;
   qpps_pkg::ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qpps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qpps_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = qpps_pkg::ST_CALC;
            end
         end
         qpps_pkg::ST_CALC: begin
            if (status.is_tick) begin
               state_in = qpps_pkg::ST_MUL;
            end else begin
               state_in = qpps_pkg::ST_EMIT;
            end
         end
         qpps_pkg::ST_MUL: begin
            state_in = qpps_pkg::ST_EMIT;
         end
         qpps_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = qpps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qpps_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         qpps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         qpps_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
         end
         qpps_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         qpps_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/qpps_datapath.sv
`default_nettype none

module qpps_datapath #(
   parameter int unsigned MOTOR_COUNT = qpps_pkg::MOTOR_COUNT_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [qpps_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [1:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [qpps_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [0:0]                            rsp_tuser,
   input  wire logic                             csr_valid,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [15:0]                      csr_data,
   input  wire qpps_pkg::dp_cmd_type             cmd,
   output qpps_pkg::dp_status_type               status
);

   localparam int unsigned IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam logic [4:0] MOTOR_LIMIT = 5'(MOTOR_COUNT);

   // configuration registers
   logic [15:0] period_ff;
   logic [15:0] gain_ff;
   logic [2:0]  mask_ff;
   logic [15:0] limit_ff;

   // captured item
   qpps_pkg::op_type op_ff;
   logic [1:0]       motor_ff;
   logic [1:0]       phases_ff;
   logic [31:0]      new_target_ff;

   // per-motor state
   logic [1:0]  prev_ff [MOTOR_COUNT];
   logic [31:0] pos_ff  [MOTOR_COUNT];
   logic [15:0] tgt_ff  [MOTOR_COUNT];

   // control term pipeline
   logic [15:0] abs_lo_ff;
   logic        abs_big_ff;
   logic        rev_ff;
   logic [16:0] mag_ff;
   logic [16:0] mag_in;

   // result register
   logic                            rsp_valid_ff;
   logic [qpps_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [qpps_pkg::RSP_DATA_W-1:0] rsp_data_in;
   logic                            rsp_upd_ff;
   logic                            rsp_upd_in;

   logic [IDX_W-1:0] sel;
   logic             motor_ok;
   logic [1:0]       cur_prev;
   logic [31:0]      cur_pos;
   logic [15:0]      cur_tgt;
   logic [3:0]       trans;
   logic [3:0]       mask4;
   logic             neg;
   logic             step_up;
   logic             step_dn;
   logic [31:0]      pos_in;
   logic             tgt_ok;
   logic [33:0]      err;
   logic [33:0]      err_negated;
   logic [32:0]      err_abs;
   logic [31:0]      prod1;
   logic [32:0]      prod2;
   logic [16:0]      level_raw;
   logic [15:0]      level_limit;
   logic [15:0]      level;
   logic             is_tick;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= qpps_pkg::PWM_PERIOD_RESET;
         gain_ff   <= qpps_pkg::GAIN_RESET;
         mask_ff   <= qpps_pkg::REVERSE_MASK_RESET;
         limit_ff  <= qpps_pkg::TARGET_LIMIT_RESET;
      end else if (csr_valid) begin
         case (qpps_pkg::csr_index_type'(csr_index))
            qpps_pkg::CSR_PWM_PERIOD:   period_ff <= csr_data;
            qpps_pkg::CSR_GAIN:         gain_ff   <= csr_data;
            qpps_pkg::CSR_REVERSE_MASK: mask_ff   <= csr_data[2:0];
            qpps_pkg::CSR_TARGET_LIMIT: limit_ff  <= csr_data;
            default:                    limit_ff  <= limit_ff;
         endcase
      end
   end

   // capture the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff         <= qpps_pkg::op_type'(req_tuser);
         motor_ff      <= req_tdata[1:0];
         phases_ff     <= req_tdata[3:2];
         new_target_ff <= req_tdata[35:4];
      end
   end

   // selected motor
   assign sel      = IDX_W'(motor_ff);
   assign motor_ok = ({3'b000, motor_ff} < MOTOR_LIMIT);
   assign cur_prev = prev_ff[sel];
   assign cur_pos  = pos_ff[sel];
   assign cur_tgt  = tgt_ff[sel];
   assign is_tick  = (op_ff == qpps_pkg::OP_TICK);

   // quadrature step, direction swapped by the motor's mask bit
   assign trans   = {cur_prev, phases_ff};
   assign mask4   = {1'b0, mask_ff};
   assign neg     = mask4[motor_ff];
   assign step_up = neg ? qpps_pkg::STEP_DOWN[trans] : qpps_pkg::STEP_UP[trans];
   assign step_dn = neg ? qpps_pkg::STEP_UP[trans] : qpps_pkg::STEP_DOWN[trans];

   always_comb begin
      if (step_up) begin
         pos_in = cur_pos + 32'd1;
      end else if (step_dn) begin
         pos_in = cur_pos - 32'd1;
      end else begin
         pos_in = cur_pos;
      end
   end

   // target accepted only in 0..limit
   assign tgt_ok = !new_target_ff[31] && (new_target_ff[30:16] == 15'd0)
                   && (new_target_ff[15:0] <= limit_ff);

   // per-motor state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            prev_ff[m] <= 2'b00;
            pos_ff[m]  <= qpps_pkg::POSITION_RESET;
            tgt_ff[m]  <= qpps_pkg::TARGET_RESET;
         end
      end else if (cmd.calc && motor_ok) begin
         if (op_ff == qpps_pkg::OP_ENCODER) begin
            prev_ff[sel] <= phases_ff;
            pos_ff[sel]  <= pos_in;
         end else if (op_ff == qpps_pkg::OP_SET_TARGET && tgt_ok) begin
            tgt_ff[sel] <= new_target_ff[15:0];
         end
      end
   end

   // position error, sign and magnitude
   assign err         = {18'd0, cur_tgt} - {{2{cur_pos[31]}}, cur_pos};
   assign err_negated = -err;
   assign err_abs     = err[33] ? err_negated[32:0] : err[32:0];

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         abs_lo_ff  <= err_abs[15:0];
         abs_big_ff <= |err_abs[32:16];
         rev_ff     <= err[33] && (gain_ff != 16'd0);
      end
   end

   // gain times error, saturated at one full scale
   assign prod1 = {16'd0, gain_ff} * {16'd0, abs_lo_ff};

   always_comb begin
      if ((abs_big_ff && gain_ff != 16'd0) || (prod1[31:16] != 16'd0)) begin
         mag_in = qpps_pkg::MAG_SATURATE;
      end else begin
         mag_in = {1'b0, prod1[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         mag_ff <= mag_in;
      end
   end

   // scale by period, clamp at period minus two
   assign prod2       = {16'd0, mag_ff} * {17'd0, period_ff};
   assign level_raw   = prod2[32:16];
   assign level_limit = (period_ff >= 16'd2) ? (period_ff - 16'd2) : 16'd0;
   assign level       = (level_raw >= {1'b0, level_limit}) ? level_limit : level_raw[15:0];

   // result beat
   always_comb begin
      rsp_data_in = '0;
      rsp_upd_in  = 1'b0;
      if (motor_ok) begin
         rsp_data_in[31:0]  = cur_pos;
         rsp_data_in[47:32] = cur_tgt;
         if (is_tick) begin
            rsp_data_in[63:48] = level;
            rsp_data_in[64]    = rev_ff;
            rsp_upd_in         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_upd_ff  <= rsp_upd_in;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_upd_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign status.is_tick  = is_tick;

endmodule

`default_nettype wire

>>> hdl/quadrature_position_p_servo.sv
`default_nettype none

// Quadrature decoder and proportional position servo for MOTOR_COUNT motors.
// Each request beat is an encoder sample, a target write, a control tick or a
// position read for one motor, and each gives exactly one response beat with
// that motor's position and target; on a control tick the drive level and
// direction come along and rsp_tuser is set. A motor index at or beyond
// MOTOR_COUNT changes nothing and returns all zeros. Each item passes through
// the controller states in order: IDLE accepts the beat, CALC updates the
// motor state and forms the error, on a tick MUL registers gain times error,
// and EMIT scales by the PWM period and loads the response register, waiting
// there while that register is still full and not being taken.
// The next request is taken as soon as the result sits in the response
// register, even if it has not yet been taken; it waits only when that
// register is still full at the end of the next item.
// Configuration writes are taken every cycle and must come while idle.
module quadrature_position_p_servo #(
   parameter int unsigned MOTOR_COUNT = qpps_pkg::MOTOR_COUNT_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // motor[1:0], phases[3:2], new_target[35:4], zero fill
   input  wire logic [qpps_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation[1:0]
   input  wire logic [1:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // position[31:0], target[47:32], drive_level[63:48], drive_reverse[64], zero fill
   output logic [qpps_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // drive_update[0]
   output logic [0:0]                            rsp_tuser,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [15:0]                      csr_data
);

   qpps_pkg::dp_cmd_type    cmd;
   qpps_pkg::dp_status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   qpps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   qpps_datapath #(
      .MOTOR_COUNT (MOTOR_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire
